### hdl/rol_pkg.sv
package rol_pkg;

  localparam int unsigned KeyWidth = 31;

  typedef logic [2:0] action_t;
  typedef logic [2:0] status_t;
  typedef logic [3:0] op_t;

  localparam action_t ACT_APPEND  = 3'd0;
  localparam action_t ACT_INSERT  = 3'd1;
  localparam action_t ACT_TO_HEAD = 3'd2;
  localparam action_t ACT_TO_TAIL = 3'd3;
  localparam action_t ACT_UP      = 3'd4;
  localparam action_t ACT_DOWN    = 3'd5;
  localparam action_t ACT_READ    = 3'd6;

  localparam status_t ST_DONE      = 3'd0;
  localparam status_t ST_NOT_FOUND = 3'd1;
  localparam status_t ST_AT_END    = 3'd2;
  localparam status_t ST_FULL      = 3'd3;
  localparam status_t ST_EMPTY     = 3'd4;
  localparam status_t ST_RANGE     = 3'd5;

  localparam op_t OP_NONE       = 4'd0;
  localparam op_t OP_LOAD       = 4'd1;
  localparam op_t OP_SCAN_START = 4'd2;
  localparam op_t OP_SCAN       = 4'd3;
  localparam op_t OP_READ       = 4'd4;
  localparam op_t OP_SET_SHIFT  = 4'd5;
  localparam op_t OP_SH_START   = 4'd6;
  localparam op_t OP_SH_MOVE    = 4'd7;
  localparam op_t OP_WRITE_KEY  = 4'd8;
  localparam op_t OP_RESULT     = 4'd9;

  typedef struct packed {
    op_t     op;
    status_t code;
    logic    use_key;
  } rol_cmd_t;

  typedef struct packed {
    action_t action;
    logic    full;
    logic    empty;
    logic    range_err;
    logic    match;
    logic    miss;
    logic    at_head;
    logic    at_tail;
    logic    cur_eq_end;
    logic    nxt_eq_end;
    logic    out_free;
  } rol_sts_t;

endpackage

### hdl/rol_ctrl.sv
module rol_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rol_pkg::rol_sts_t sts_i,
  output rol_pkg::rol_cmd_t cmd_o
);
  import rol_pkg::*;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_DECODE    = 3'd1;
  localparam logic [2:0] S_SCAN      = 3'd2;
  localparam logic [2:0] S_CHECK     = 3'd3;
  localparam logic [2:0] S_SH_START  = 3'd4;
  localparam logic [2:0] S_SH_MOVE   = 3'd5;
  localparam logic [2:0] S_WRITE_KEY = 3'd6;
  localparam logic [2:0] S_RESULT    = 3'd7;

  logic [2:0] state_q, state_d;
  status_t    code_q, code_d;
  logic       use_key_q, use_key_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d       = state_q;
    code_d        = code_q;
    use_key_d     = use_key_q;
    cmd_o.op      = OP_NONE;
    cmd_o.code    = code_q;
    cmd_o.use_key = use_key_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op  = OP_LOAD;
          use_key_d = 1'b0;
          code_d    = ST_DONE;
          state_d   = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts_i.action)
          ACT_APPEND, ACT_INSERT: begin
            if (sts_i.full) begin
              code_d  = ST_FULL;
              state_d = S_RESULT;
            end else begin
              cmd_o.op = OP_SET_SHIFT;
              state_d  = S_SH_START;
            end
          end
          ACT_TO_HEAD, ACT_TO_TAIL, ACT_UP, ACT_DOWN: begin
            if (sts_i.empty) begin
              code_d  = ST_EMPTY;
              state_d = S_RESULT;
            end else begin
              cmd_o.op = OP_SCAN_START;
              state_d  = S_SCAN;
            end
          end
          ACT_READ: begin
            state_d = S_RESULT;
            if (sts_i.empty) begin
              code_d = ST_EMPTY;
            end else if (sts_i.range_err) begin
              code_d = ST_RANGE;
            end else begin
              cmd_o.op  = OP_READ;
              use_key_d = 1'b1;
            end
          end
          default: begin
            state_d = S_RESULT;
          end
        endcase
      end
      S_SCAN: begin
        if (sts_i.match) begin
          state_d = S_CHECK;
        end else if (sts_i.miss) begin
          code_d  = ST_NOT_FOUND;
          state_d = S_RESULT;
        end else begin
          cmd_o.op = OP_SCAN;
        end
      end
      S_CHECK: begin
        if ((sts_i.action == ACT_TO_HEAD || sts_i.action == ACT_UP) && sts_i.at_head) begin
          code_d  = ST_AT_END;
          state_d = S_RESULT;
        end else if ((sts_i.action == ACT_TO_TAIL || sts_i.action == ACT_DOWN) &&
                     sts_i.at_tail) begin
          code_d  = ST_AT_END;
          state_d = S_RESULT;
        end else begin
          cmd_o.op = OP_SET_SHIFT;
          state_d  = S_SH_START;
        end
      end
      S_SH_START: begin
        if (sts_i.cur_eq_end) begin
          state_d = S_WRITE_KEY;
        end else begin
          cmd_o.op = OP_SH_START;
          state_d  = S_SH_MOVE;
        end
      end
      S_SH_MOVE: begin
        cmd_o.op = OP_SH_MOVE;
        if (sts_i.nxt_eq_end) begin
          state_d = S_WRITE_KEY;
        end
      end
      S_WRITE_KEY: begin
        cmd_o.op = OP_WRITE_KEY;
        state_d  = S_RESULT;
      end
      S_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_RESULT;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      code_q    <= ST_DONE;
      use_key_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      code_q    <= code_d;
      use_key_q <= use_key_d;
    end
  end

endmodule

### hdl/rol_datapath.sv
module rol_datapath #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rol_pkg::rol_cmd_t            cmd_i,
  output rol_pkg::rol_sts_t            sts_o,
  input  rol_pkg::action_t             action_i,
  input  logic [rol_pkg::KeyWidth-1:0] key_id_i,
  input  logic [3:0]                   read_index_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output rol_pkg::status_t             status_o,
  output logic [rol_pkg::KeyWidth-1:0] read_key_o,
  output logic [4:0]                   entry_count_o
);
  import rol_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > 4) ? CW : 4;

  logic [KeyWidth-1:0] mem_q [DEPTH];
  logic [KeyWidth-1:0] rd_data_q;

  action_t             action_q;
  logic [KeyWidth-1:0] key_q;
  logic [3:0]          ridx_q;
  logic [CW-1:0]       count_q;
  logic [CW-1:0]       scan_q;
  logic                chk_q;
  logic [AW-1:0]       chk_idx_q;
  logic [AW-1:0]       cur_q;
  logic [AW-1:0]       tgt_q;
  logic                dec_q;

  logic                out_valid_q;
  status_t             out_status_q;
  logic [KeyWidth-1:0] out_key_q;
  logic [4:0]          out_count_q;

  logic                mem_we;
  logic [AW-1:0]       mem_wa;
  logic [KeyWidth-1:0] mem_wd;
  logic                mem_re;
  logic [AW-1:0]       mem_ra;

  logic [AW-1:0]       n_idx;
  logic [AW-1:0]       last_idx;
  logic [AW-1:0]       nxt;
  logic [AW-1:0]       nxt2;
  logic                scan_lt_n;
  logic                is_ins;
  logic [CW+4:0]       count_ext;

  assign n_idx     = count_q[AW-1:0];
  assign last_idx  = AW'(count_q - 1'b1);
  assign nxt       = dec_q ? AW'(cur_q - 1'b1) : AW'(cur_q + 1'b1);
  assign nxt2      = dec_q ? AW'(nxt - 1'b1) : AW'(nxt + 1'b1);
  assign scan_lt_n = (scan_q < count_q);
  assign is_ins    = (action_q == ACT_APPEND) || (action_q == ACT_INSERT);
  assign count_ext = {5'b00000, count_q};

  always_comb begin
    sts_o.action     = action_q;
    sts_o.full       = (count_q == CW'(DEPTH));
    sts_o.empty      = (count_q == '0);
    sts_o.range_err  = (XW'(ridx_q) >= XW'(count_q));
    sts_o.match      = chk_q && (rd_data_q == key_q);
    sts_o.miss       = !chk_q;
    sts_o.at_head    = (chk_idx_q == '0);
    sts_o.at_tail    = (chk_idx_q == last_idx);
    sts_o.cur_eq_end = (cur_q == tgt_q);
    sts_o.nxt_eq_end = (nxt == tgt_q);
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = cur_q;
    mem_wd = rd_data_q;
    mem_re = 1'b0;
    mem_ra = nxt;
    case (cmd_i.op)
      OP_SCAN_START: begin
        mem_re = 1'b1;
        mem_ra = '0;
      end
      OP_SCAN: begin
        mem_re = scan_lt_n;
        mem_ra = scan_q[AW-1:0];
      end
      OP_READ: begin
        mem_re = 1'b1;
        mem_ra = AW'(ridx_q);
      end
      OP_SH_START: begin
        mem_re = 1'b1;
        mem_ra = nxt;
      end
      OP_SH_MOVE: begin
        mem_we = 1'b1;
        mem_wa = cur_q;
        mem_wd = rd_data_q;
        mem_re = (nxt != tgt_q);
        mem_ra = nxt2;
      end
      OP_WRITE_KEY: begin
        mem_we = 1'b1;
        mem_wa = tgt_q;
        mem_wd = key_q;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        action_q <= action_i;
        key_q    <= key_id_i;
        ridx_q   <= read_index_i;
      end
      OP_SCAN_START: begin
        scan_q    <= CW'(1);
        chk_q     <= 1'b1;
        chk_idx_q <= '0;
      end
      OP_SCAN: begin
        chk_q     <= scan_lt_n;
        chk_idx_q <= scan_q[AW-1:0];
        if (scan_lt_n) begin
          scan_q <= scan_q + 1'b1;
        end
      end
      OP_SET_SHIFT: begin
        case (action_q)
          ACT_APPEND: begin
            cur_q <= n_idx;
            tgt_q <= n_idx;
            dec_q <= 1'b0;
          end
          ACT_INSERT: begin
            cur_q <= n_idx;
            tgt_q <= '0;
            dec_q <= 1'b1;
          end
          ACT_TO_HEAD: begin
            cur_q <= chk_idx_q;
            tgt_q <= '0;
            dec_q <= 1'b1;
          end
          ACT_TO_TAIL: begin
            cur_q <= chk_idx_q;
            tgt_q <= last_idx;
            dec_q <= 1'b0;
          end
          ACT_UP: begin
            cur_q <= chk_idx_q;
            tgt_q <= AW'(chk_idx_q - 1'b1);
            dec_q <= 1'b1;
          end
          default: begin
            cur_q <= chk_idx_q;
            tgt_q <= AW'(chk_idx_q + 1'b1);
            dec_q <= 1'b0;
          end
        endcase
      end
      OP_SH_MOVE: begin
        cur_q <= nxt;
      end
      OP_RESULT: begin
        out_status_q <= cmd_i.code;
        out_key_q    <= cmd_i.use_key ? rd_data_q : '0;
        out_count_q  <= count_ext[4:0];
      end
      default: begin
        chk_q <= chk_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_WRITE_KEY && is_ins) begin
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.op == OP_RESULT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign read_key_o    = out_key_q;
  assign entry_count_o = out_count_q;

endmodule

### hdl/reorderable_ordered_list.sv
// Ordered list of up to DEPTH 31-bit keys held in a key memory with one write and one read
// port. One command is taken at a time and answered with exactly one result transaction; the
// next command is accepted in the cycle after the result is issued. A read, an unused action
// or a refused command goes from the decode straight to the result. An append writes its key
// at the tail; an insert first shifts every entry one place towards the tail and then writes
// its key at the head. Moves first scan from the head at one entry per cycle and then shift
// one entry per cycle; a missing key ends the move after the scan. The rate is set by the key
// memory, which is read at most once per cycle during the scan and read and written at most
// once per cycle during the shift. Entry counts are reported in their low five bits.
module reorderable_ordered_list #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // action[2:0], key_id[33:3], read_index[37:34]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // status[2:0], read_key[33:3], entry_count[38:34]
);
  import rol_pkg::*;

  rol_cmd_t            cmd;
  rol_sts_t            sts;
  status_t             status;
  logic [KeyWidth-1:0] read_key;
  logic [4:0]          entry_count;

  rol_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rol_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .action_i      (s_axis_tdata[2:0]),
    .key_id_i      (s_axis_tdata[33:3]),
    .read_index_i  (s_axis_tdata[37:34]),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .status_o      (status),
    .read_key_o    (read_key),
    .entry_count_o (entry_count)
  );

  assign m_axis_tdata = {1'b0, entry_count, read_key, status};

endmodule
